// ----- rtl/core/apsp_pkg.sv -----
// Shared types, constants and helper functions of the polar scope point generator.
package apsp_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int GAIN_W   = 16;
    localparam int RADIUS_W = 15;
    localparam int PHASE_W  = 32;
    localparam int POINT_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BOOST_GAIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 4'd3;

    localparam logic [GAIN_W-1:0]   BOOST_GAIN_RST = 16'd6963;
    localparam logic [RADIUS_W-1:0] MIN_RADIUS_RST = 15'd6554;
    localparam logic [RADIUS_W-1:0] MAX_RADIUS_RST = 15'd24576;
    localparam logic [PHASE_W-1:0]  PHASE_STEP_RST = 32'd11704837;

    localparam int CORDIC_ITERS = 20;
    localparam int ITER_W       = 5;
    localparam int ROT_W        = 34;
    localparam logic [15:0] CORDIC_GAIN_Q16 = 16'd39797;

    typedef struct packed {
        logic              load;
        logic              gain;
        logic              span;
        logic              scale;
        logic              rotate;
        logic              round;
        logic [ITER_W-1:0] iter;
    } ctrl_cmd_t;

    // Arctangent of 2^-i in turns scaled by 2^32.
    function automatic logic [31:0] atan_turns(input logic [ITER_W-1:0] i);
        logic [31:0] a;
        begin
            case (i)
                5'd0:    a = 32'h20000000;
                5'd1:    a = 32'h12E4051E;
                5'd2:    a = 32'h09FB385B;
                5'd3:    a = 32'h051111D4;
                5'd4:    a = 32'h028B0D43;
                5'd5:    a = 32'h0145D7E1;
                5'd6:    a = 32'h00A2F61E;
                5'd7:    a = 32'h00517C55;
                5'd8:    a = 32'h0028BE53;
                5'd9:    a = 32'h00145F2F;
                5'd10:   a = 32'h000A2F98;
                5'd11:   a = 32'h000517CC;
                5'd12:   a = 32'h00028BE6;
                5'd13:   a = 32'h000145F3;
                5'd14:   a = 32'h0000A2FA;
                5'd15:   a = 32'h0000517D;
                5'd16:   a = 32'h000028BE;
                5'd17:   a = 32'h0000145F;
                5'd18:   a = 32'h00000A30;
                5'd19:   a = 32'h00000518;
                default: a = 32'h00000000;
            endcase
            return a;
        end
    endfunction

    // Rounds a Q16-scaled CORDIC coordinate to Q1.15 and saturates it.
    function automatic logic signed [POINT_W-1:0] round_sat(input logic signed [ROT_W-1:0] v);
        logic signed [ROT_W:0] r;
        logic signed [POINT_W-1:0] q;
        begin
            r = ($signed({v[ROT_W-1], v}) + $signed((ROT_W+1)'(32768))) >>> 16;
            if (r > $signed((ROT_W+1)'(32767)))
                q = 16'sh7FFF;
            else if (r < -$signed((ROT_W+1)'(32768)))
                q = 16'sh8000;
            else
                q = r[POINT_W-1:0];
            return q;
        end
    endfunction

endpackage

// ----- rtl/core/apsp_ifs.sv -----
// Handshake channel interfaces for samples, points and configuration writes.
interface apsp_sample_if #(
    parameter int SAMPLE_BITS = apsp_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface apsp_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [apsp_pkg::POINT_W-1:0] point_x;
    logic signed [apsp_pkg::POINT_W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface apsp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [apsp_pkg::CFG_IDX_W-1:0]    index;
    logic [apsp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/audio_polar_scope_point_generator_unit.sv -----
// Top level of the polar scope point generator: channels, controller and datapath.
//
//  channel     dir  payload                         transfer when
//  sample_in   in   left_sample, right_sample       valid & ready
//  point_out   out  point_x, point_y                valid & ready
//  cfg         in   index, data                     valid & ready (ready is always high)
//
// Each sample pair passes from its transfer through the gain multiply, the radius span
// multiply and the CORDIC gain multiply, 20 CORDIC iterations on one shared shift-add unit,
// and a rounding step into the output register, after which its point is valid.
// A new pair is taken in the cycle after rounding, while the point may still wait.
// When the output is stalled, rounding waits until the previous point has been taken.
// Reset restores the register defaults and clears the phase accumulator.
module audio_polar_scope_point_generator_unit #(
    parameter int SAMPLE_BITS = apsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    apsp_sample_if.sink    sample_in,
    apsp_point_if.source   point_out,
    apsp_cfg_if.sink       cfg
);

    apsp_pkg::ctrl_cmd_t cmd;

    assign cfg.ready = 1'b1;

    apsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (point_out.valid),
        .out_ready (point_out.ready),
        .cmd       (cmd)
    );

    apsp_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .left_sample  (sample_in.left_sample),
        .right_sample (sample_in.right_sample),
        .point_x      (point_out.point_x),
        .point_y      (point_out.point_y)
    );

`ifndef SYNTHESIS
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !sample_in.ready)
        else $error("sample channel still ready after a transfer");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.gain, cmd.span, cmd.scale, cmd.rotate, cmd.round}))
        else $error("more than one datapath step in a cycle");

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rotate |-> (cmd.iter < apsp_pkg::ITER_W'(apsp_pkg::CORDIC_ITERS)))
        else $error("CORDIC iteration index out of range");

    a_round_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |=> point_out.valid)
        else $error("rounded point not presented");
`endif

endmodule

// ----- rtl/core/apsp_ctrl.sv -----
// Sequencer that steps one sample pair through gain, mapping, CORDIC and rounding.
module apsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output apsp_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GAIN   = 3'd1;
    localparam logic [2:0] S_SPAN   = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_ROTATE = 3'd4;
    localparam logic [2:0] S_ROUND  = 3'd5;

    localparam logic [apsp_pkg::ITER_W-1:0] ITER_LAST =
        apsp_pkg::ITER_W'(apsp_pkg::CORDIC_ITERS - 1);

    logic [2:0]                    state_reg, state_next;
    logic [apsp_pkg::ITER_W-1:0]   iter_reg, iter_next;
    logic                          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.iter   = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                cmd.span   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                iter_next  = '0;
                state_next = S_ROTATE;
            end
            S_ROTATE:
            begin
                cmd.rotate = 1'b1;
                if (iter_reg == ITER_LAST)
                    state_next = S_ROUND;
                else
                    iter_next = iter_reg + 1'b1;
            end
            S_ROUND:
            begin
                // The result register is only overwritten once the previous point is gone.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.round  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.round | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/apsp_dpath.sv -----
// Datapath: configuration registers, phase accumulator, gain and radius math, CORDIC rotator.
module apsp_dpath #(
    parameter int SAMPLE_BITS = apsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  apsp_pkg::ctrl_cmd_t                 cmd,
    input  logic                                cfg_we,
    input  logic [apsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [apsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       right_sample,
    output logic signed [apsp_pkg::POINT_W-1:0] point_x,
    output logic signed [apsp_pkg::POINT_W-1:0] point_y
);

    localparam int PROD_W = SAMPLE_BITS + 18;
    localparam int RW     = apsp_pkg::ROT_W;
    localparam logic signed [PROD_W-1:0] MONO_RND = PROD_W'(1) << (SAMPLE_BITS - 4);
    localparam logic signed [PROD_W-1:0] MONO_HI  = PROD_W'(32768);
    localparam logic signed [PROD_W-1:0] MONO_LO  = -PROD_W'(32768);

    logic [apsp_pkg::GAIN_W-1:0]   boost_gain_reg;
    logic [apsp_pkg::RADIUS_W-1:0] min_radius_reg;
    logic [apsp_pkg::RADIUS_W-1:0] max_radius_reg;
    logic [apsp_pkg::PHASE_W-1:0]  phase_step_reg;
    logic [apsp_pkg::PHASE_W-1:0]  phase_acc_reg;

    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic                          flip_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [32:0]            span_reg;
    logic signed [RW-1:0]          x_reg, y_reg, z_reg;
    logic signed [apsp_pkg::POINT_W-1:0] point_x_reg, point_y_reg;

    logic signed [SAMPLE_BITS:0]   sum_w;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      mono_wide;
    logic signed [16:0]            mono;
    logic [17:0]                   t_sum;
    logic [15:0]                   t_unit;
    logic signed [15:0]            span_delta;
    logic signed [32:0]            span_next;
    logic signed [32:0]            span_q;
    logic signed [17:0]            rad_w;
    logic [apsp_pkg::RADIUS_W-1:0] rad;
    logic [30:0]                   rad_prod;
    logic signed [RW-1:0]          dx, dy, atan_w;
    logic [apsp_pkg::PHASE_W-1:0]  phase_red;
    logic signed [RW-1:0]          x_fin, y_fin;

    always_comb
    begin
        sum_w      = $signed({left_reg[SAMPLE_BITS-1], left_reg})
                   + $signed({right_reg[SAMPLE_BITS-1], right_reg});
        prod_next  = sum_w * $signed({1'b0, boost_gain_reg});

        mono_wide = (prod_reg + MONO_RND) >>> (SAMPLE_BITS - 3);
        if (mono_wide > MONO_HI)
            mono = 17'sd32768;
        else if (mono_wide < MONO_LO)
            mono = -17'sd32768;
        else
            mono = mono_wide[16:0];
        t_sum      = 18'($signed({mono[16], mono}) + 18'sd32768);
        t_unit     = t_sum[16:1];
        span_delta = $signed({1'b0, max_radius_reg}) - $signed({1'b0, min_radius_reg});
        span_next  = $signed({1'b0, t_unit}) * span_delta;

        span_q   = (span_reg + 33'sd16384) >>> 15;
        rad_w    = $signed({3'b000, min_radius_reg}) + span_q[17:0];
        rad      = rad_w[apsp_pkg::RADIUS_W-1:0];
        rad_prod = 31'(rad) * 31'(apsp_pkg::CORDIC_GAIN_Q16);

        dx     = y_reg >>> cmd.iter;
        dy     = x_reg >>> cmd.iter;
        atan_w = $signed({2'b00, apsp_pkg::atan_turns(cmd.iter)});

        // Phases in the left half plane are rotated by half a turn and the result negated.
        phase_red = phase_acc_reg ^ {(phase_acc_reg[31] ^ phase_acc_reg[30]), 31'd0};

        x_fin = flip_reg ? -x_reg : x_reg;
        y_fin = flip_reg ? -y_reg : y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boost_gain_reg <= apsp_pkg::BOOST_GAIN_RST;
            min_radius_reg <= apsp_pkg::MIN_RADIUS_RST;
            max_radius_reg <= apsp_pkg::MAX_RADIUS_RST;
            phase_step_reg <= apsp_pkg::PHASE_STEP_RST;
            phase_acc_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    apsp_pkg::REG_BOOST_GAIN: boost_gain_reg <= cfg_data[apsp_pkg::GAIN_W-1:0];
                    apsp_pkg::REG_MIN_RADIUS: min_radius_reg <= cfg_data[apsp_pkg::RADIUS_W-1:0];
                    apsp_pkg::REG_MAX_RADIUS: max_radius_reg <= cfg_data[apsp_pkg::RADIUS_W-1:0];
                    apsp_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data[apsp_pkg::PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
                phase_acc_reg <= phase_acc_reg + phase_step_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
            flip_reg  <= phase_acc_reg[31] ^ phase_acc_reg[30];
            z_reg     <= $signed({{(RW-32){phase_red[31]}}, phase_red});
        end
        if (cmd.gain)
            prod_reg <= prod_next;
        if (cmd.span)
            span_reg <= span_next;
        if (cmd.scale)
        begin
            x_reg <= $signed({3'b000, rad_prod});
            y_reg <= '0;
        end
        if (cmd.rotate)
        begin
            if (!z_reg[RW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_w;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_w;
            end
        end
        if (cmd.round)
        begin
            point_x_reg <= apsp_pkg::round_sat(x_fin);
            point_y_reg <= apsp_pkg::round_sat(y_fin);
        end
    end

    assign point_x = point_x_reg;
    assign point_y = point_y_reg;

endmodule
